@@ src/wth_pkg.sv @@
// ----------------------------------------------------------------------------
// wth_pkg
// Shared types and constants of the window table hit test block.
// ----------------------------------------------------------------------------
`default_nettype none

package wth_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    typedef enum logic [2:0] {
        MODE_CREATE   = 3'd0,
        MODE_DESTROY  = 3'd1,
        MODE_GEOMETRY = 3'd2,
        MODE_FOCUS    = 3'd3,
        MODE_MINIMIZE = 3'd4,
        MODE_RESTORE  = 3'd5,
        MODE_HIT      = 3'd6,
        MODE_NONE     = 3'd7
    } t_mode;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [2:0] ZONE_NONE   = 3'd0;
    localparam logic [2:0] ZONE_CLOSE  = 3'd1;
    localparam logic [2:0] ZONE_MAX    = 3'd2;
    localparam logic [2:0] ZONE_MIN    = 3'd3;
    localparam logic [2:0] ZONE_TITLE  = 3'd4;
    localparam logic [2:0] ZONE_RESIZE = 3'd5;
    localparam logic [2:0] ZONE_BORDER = 3'd6;
    localparam logic [2:0] ZONE_CLIENT = 3'd7;

    localparam logic [1:0] CFG_BORDER = 2'd0;
    localparam logic [1:0] CFG_BUTTON = 2'd1;
    localparam logic [1:0] CFG_TITLE  = 2'd2;
    localparam logic [1:0] CFG_GRAB   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH,
        S_CLASS,
        S_OUT
    } t_state;

    // scan kinds
    typedef enum logic [1:0] {
        SCAN_FREE,
        SCAN_FOCUS_ALL,
        SCAN_FOCUS_SHOWN,
        SCAN_HIT
    } t_scan;

    typedef struct packed {
        logic         load;
        logic         exec;
        logic         scan_clear;
        logic         scan_step;
        logic         finish;
        logic         classify;
        t_scan        scan_kind;
        logic [SLOT_W-1:0] scan_idx;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  need_scan;
        t_scan scan_kind;
        logic  finish_skip;
    } t_stat;

endpackage

`default_nettype wire

@@ src/wth_ctrl.sv @@
// ----------------------------------------------------------------------------
// wth_ctrl
// Sequencer: load, execute, optional slot scan followed by finish or classify, output.
// ----------------------------------------------------------------------------
`default_nettype none

module wth_ctrl
    import wth_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  wire logic  i_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_scan r_kind, n_kind;
    logic r_cls, n_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_kind  <= SCAN_FREE;
            r_cls   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
            r_cls   <= n_cls;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        n_cls   = r_cls;
        o_cmd   = '0;
        o_cmd.scan_kind = r_kind;
        o_cmd.scan_idx  = r_cnt[SLOT_W-1:0];
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                o_cmd.scan_clear = 1'b1;
                n_kind = i_stat.scan_kind;
                n_cls  = (i_stat.scan_kind == SCAN_HIT);
                n_cnt  = '0;
                if (i_stat.need_scan) n_state = S_SCAN;
                else n_state = S_OUT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAX_SLOTS - 1)) begin
                    n_state = r_cls ? S_CLASS : S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_stall) |=> (r_state == S_OUT))
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("accept while busy");
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cnt == CNT_W'(MAX_SLOTS - 1)) |=>
        (r_state == S_CLASS || r_state == S_FINISH))
        else $error("scan length wrong");

endmodule

`default_nettype wire

@@ src/wth_dpath.sv @@
// ----------------------------------------------------------------------------
// wth_dpath
// Slot table, config registers, operation execution, scan and zone logic.
// ----------------------------------------------------------------------------
`default_nettype none

module wth_dpath
    import wth_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic [2:0]  i_mode,
    input  wire logic [3:0]  i_slot,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic [15:0] i_outer_w,
    input  wire logic [15:0] i_outer_h,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic [1:0]       o_status,
    output logic             o_hit_valid,
    output logic [3:0]       o_hit_slot,
    output logic [2:0]       o_zone,
    output logic             o_focus_valid,
    output logic [3:0]       o_focus_slot
);

    logic [MAX_SLOTS-1:0] r_present, r_visible, r_min, r_focused;
    logic signed [15:0] r_left [MAX_SLOTS];
    logic signed [15:0] r_top  [MAX_SLOTS];
    logic [15:0] r_wd [MAX_SLOTS];
    logic [15:0] r_ht [MAX_SLOTS];
    logic [7:0]  r_z  [MAX_SLOTS];
    logic        r_fok;
    logic [SLOT_W-1:0] r_fslot;
    logic [7:0]  r_next;
    logic [5:0]  r_bw;
    logic [7:0]  r_bt, r_th, r_rg;

    t_mode r_mode;
    logic [3:0] r_slot;
    logic signed [15:0] r_px, r_py;
    logic [15:0] r_w, r_h;

    logic r_found;
    logic [SLOT_W-1:0] r_best;
    logic [7:0] r_bz;
    logic signed [17:0] r_rx, r_ry;
    logic [15:0] r_bww, r_bwh;

    logic [1:0] r_status;
    logic r_hv;
    logic [3:0] r_hs;
    logic [2:0] r_zone;

    logic [SLOT_W-1:0] s_idx;
    logic s_in_range, s_ok;
    logic s_elig, s_inside, s_take;
    logic signed [17:0] s_rx, s_ry;

    assign s_in_range = ({1'b0, r_slot} < 5'(MAX_SLOTS));
    assign s_idx = r_slot[SLOT_W-1:0];
    assign s_ok = s_in_range && r_present[s_idx];

    always_comb begin
        o_stat.mode = r_mode;
        o_stat.need_scan = 1'b0;
        o_stat.scan_kind = SCAN_FREE;
        o_stat.finish_skip = 1'b0;
        unique case (r_mode)
            MODE_CREATE: o_stat.need_scan = 1'b1;
            MODE_DESTROY: begin
                o_stat.need_scan = s_ok && r_fok && (r_fslot == s_idx);
                o_stat.scan_kind = SCAN_FOCUS_ALL;
            end
            MODE_MINIMIZE: begin
                o_stat.need_scan = s_ok && !r_min[s_idx] && r_fok && (r_fslot == s_idx);
                o_stat.scan_kind = SCAN_FOCUS_SHOWN;
            end
            MODE_HIT: begin
                o_stat.need_scan = 1'b1;
                o_stat.scan_kind = SCAN_HIT;
            end
            default: ;
        endcase
    end

    logic [SLOT_W-1:0] c;
    assign c = i_cmd.scan_idx;
    assign s_rx = 18'(r_px) - 18'(r_left[c]);
    assign s_ry = 18'(r_py) - 18'(r_top[c]);
    assign s_inside = !s_rx[17] && !s_ry[17] && (s_rx < $signed({2'b0, r_wd[c]}))
                      && (s_ry < $signed({2'b0, r_ht[c]}));

    always_comb begin
        s_elig = 1'b0;
        s_take = 1'b0;
        unique case (i_cmd.scan_kind)
            SCAN_FREE: begin
                s_elig = !r_present[c];
                s_take = s_elig && !r_found;
            end
            SCAN_FOCUS_ALL: begin
                s_elig = r_present[c] && r_visible[c];
                s_take = s_elig && (r_z[c] >= r_bz);
            end
            SCAN_FOCUS_SHOWN: begin
                s_elig = r_present[c] && r_visible[c] && !r_min[c];
                s_take = s_elig && (r_z[c] >= r_bz);
            end
            SCAN_HIT: begin
                s_elig = r_present[c] && r_visible[c] && !r_min[c] && s_inside;
                s_take = s_elig && (!r_found || r_z[c] >= r_bz);
            end
            default: ;
        endcase
    end

    // zone classification on the registered relative point
    logic signed [19:0] z_bw, z_bt, z_th, z_rg, z_ww, z_wh, z_rx, z_ry;
    logic signed [19:0] z_cx, z_mx, z_nx;
    logic [2:0] z_zone;
    always_comb begin
        z_bw = 20'(r_bw);
        z_bt = 20'(r_bt);
        z_th = 20'(r_th);
        z_rg = 20'(r_rg);
        z_ww = 20'(r_bww);
        z_wh = 20'(r_bwh);
        z_rx = 20'(r_rx);
        z_ry = 20'(r_ry);
        z_cx = z_ww - z_bw - z_bt;
        z_mx = z_cx - z_bt;
        z_nx = z_mx - z_bt;
        priority if (z_ry < z_th) begin
            priority if (z_rx >= z_cx && z_rx < z_cx + z_bt) z_zone = ZONE_CLOSE;
            else if (z_rx >= z_mx && z_rx < z_mx + z_bt) z_zone = ZONE_MAX;
            else if (z_rx >= z_nx && z_rx < z_nx + z_bt) z_zone = ZONE_MIN;
            else z_zone = ZONE_TITLE;
        end else if (z_rx >= z_ww - z_rg && z_ry >= z_wh - z_rg) begin
            z_zone = ZONE_RESIZE;
        end else if (z_rx < z_bw || z_rx >= z_ww - z_bw || z_ry >= z_wh - z_bw) begin
            z_zone = ZONE_BORDER;
        end else begin
            z_zone = ZONE_CLIENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_visible <= '0;
            r_min     <= '0;
            r_focused <= '0;
            r_fok     <= 1'b0;
            r_fslot   <= '0;
            r_next    <= 8'd1;
            r_bw      <= 6'd2;
            r_bt      <= 8'd24;
            r_th      <= 8'd24;
            r_rg      <= 8'd8;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BORDER: r_bw <= i_cfg_data[5:0];
                    CFG_BUTTON: r_bt <= i_cfg_data;
                    CFG_TITLE:  r_th <= i_cfg_data;
                    CFG_GRAB:   r_rg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                unique case (r_mode)
                    MODE_DESTROY: if (s_ok) begin
                        r_present[s_idx] <= 1'b0;
                        r_visible[s_idx] <= 1'b0;
                        r_focused[s_idx] <= 1'b0;
                        if (r_fok && r_fslot == s_idx) r_fok <= 1'b0;
                    end
                    MODE_FOCUS, MODE_RESTORE:
                        if (s_ok && (r_mode == MODE_FOCUS || r_min[s_idx])) begin
                            if (r_mode == MODE_RESTORE) r_min[s_idx] <= 1'b0;
                            if (r_fok) r_focused[r_fslot] <= 1'b0;
                            r_focused[s_idx] <= 1'b1;
                            r_z[s_idx] <= r_next;
                            r_next <= r_next + 8'd1;
                            r_fok <= 1'b1;
                            r_fslot <= s_idx;
                        end
                    MODE_MINIMIZE: if (s_ok && !r_min[s_idx]) begin
                        r_min[s_idx] <= 1'b1;
                        if (r_fok && r_fslot == s_idx) begin
                            r_focused[s_idx] <= 1'b0;
                            r_fok <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.finish && r_found) begin
                if (r_mode == MODE_CREATE) begin
                    r_present[r_best] <= 1'b1;
                    r_visible[r_best] <= 1'b1;
                    r_min[r_best] <= 1'b0;
                    if (r_fok) r_focused[r_fslot] <= 1'b0;
                    r_z[r_best] <= r_next + 8'd1;
                    r_next <= r_next + 8'd2;
                end else begin
                    r_z[r_best] <= r_next;
                    r_next <= r_next + 8'd1;
                end
                r_focused[r_best] <= 1'b1;
                r_fok <= 1'b1;
                r_fslot <= r_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= t_mode'(i_mode);
            r_slot <= i_slot;
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_w <= i_outer_w;
            r_h <= i_outer_h;
        end
        if (i_cmd.exec && r_mode == MODE_GEOMETRY && s_ok) begin
            r_left[s_idx] <= r_px;
            r_top[s_idx]  <= r_py;
            r_wd[s_idx]   <= r_w;
            r_ht[s_idx]   <= r_h;
        end
        if (i_cmd.finish && r_found && r_mode == MODE_CREATE) begin
            r_left[r_best] <= r_px;
            r_top[r_best]  <= r_py;
            r_wd[r_best]   <= r_w;
            r_ht[r_best]   <= r_h;
        end
        if (i_cmd.scan_clear) begin
            r_found <= 1'b0;
            r_bz <= '0;
            r_best <= '0;
        end else if (i_cmd.scan_step && s_take) begin
            r_found <= 1'b1;
            r_bz <= r_z[c];
            r_best <= c;
            r_rx <= s_rx;
            r_ry <= s_ry;
            r_bww <= r_wd[c];
            r_bwh <= r_ht[c];
        end
        if (i_cmd.exec) begin
            r_hv <= 1'b0;
            r_hs <= '0;
            r_zone <= ZONE_NONE;
            r_status <= ST_IGNORED;
            unique case (r_mode)
                MODE_DESTROY, MODE_GEOMETRY, MODE_FOCUS:
                    if (s_ok) r_status <= ST_DONE;
                MODE_MINIMIZE: if (s_ok && !r_min[s_idx]) r_status <= ST_DONE;
                MODE_RESTORE:  if (s_ok && r_min[s_idx]) r_status <= ST_DONE;
                MODE_HIT:      r_status <= ST_DONE;
                MODE_CREATE:   r_status <= ST_NO_FREE;
                default: ;
            endcase
        end
        if (i_cmd.finish && r_found && r_mode == MODE_CREATE) begin
            r_status <= ST_DONE;
            r_hv <= 1'b1;
            r_hs <= 4'(r_best);
        end
        if (i_cmd.classify && r_found) begin
            r_hv <= 1'b1;
            r_hs <= 4'(r_best);
            r_zone <= z_zone;
        end
    end

    assign o_status = r_status;
    assign o_hit_valid = r_hv;
    assign o_hit_slot = r_hs;
    assign o_zone = r_zone;
    assign o_focus_valid = r_fok;
    assign o_focus_slot = r_fok ? 4'(r_fslot) : 4'd0;

    a_focus_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && r_fok) |-> r_focused[r_fslot])
        else $error("focus holder lacks flag");
    a_focus_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> $onehot0(r_focused))
        else $error("more than one focused slot");
    a_focus_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && r_fok) |-> r_present[r_fslot])
        else $error("focus on absent slot");

endmodule

`default_nettype wire

@@ src/window_table_hit_test.sv @@
// ----------------------------------------------------------------------------
// window_table_hit_test
// Window slot table with z-ordered hit testing and focus handling.
// ----------------------------------------------------------------------------
// ops without a slot scan go load, execute, output; ops with a slot scan
// (create, hit test, focus fallback) step one slot per cycle over 16 slots
// and then finish or classify before output; one op in flight, a new op is taken after the result
// reset: synchronous active low; flags clear, no focus, depth counter 1,
// config registers to their defaults
`default_nettype none

module window_table_hit_test
    import wth_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [3:0]  i_slot,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic [15:0] i_outer_w,
    input  wire logic [15:0] i_outer_h,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic             o_hit_valid,
    output logic [3:0]       o_hit_slot,
    output logic [2:0]       o_zone,
    output logic             o_focus_valid,
    output logic [3:0]       o_focus_slot
);

    t_cmd  w_cmd;
    t_stat w_stat;

    wth_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    wth_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_mode(i_mode), .i_slot(i_slot), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_outer_w(i_outer_w), .i_outer_h(i_outer_h),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .o_status(o_status), .o_hit_valid(o_hit_valid), .o_hit_slot(o_hit_slot),
        .o_zone(o_zone), .o_focus_valid(o_focus_valid), .o_focus_slot(o_focus_slot)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives window table operations with random idling on both channels,
// predicts status, hit, zone and focus for each beat and compares them as one outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import wth_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_mode = '0;
    logic [3:0]  i_slot = '0;
    logic signed [15:0] i_pos_x = '0;
    logic signed [15:0] i_pos_y = '0;
    logic [15:0] i_outer_w = '0;
    logic [15:0] i_outer_h = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic        o_hit_valid;
    logic [3:0]  o_hit_slot;
    logic [2:0]  o_zone;
    logic        o_focus_valid;
    logic [3:0]  o_focus_slot;

    window_table_hit_test DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [1:0] status;
        logic       hit_valid;
        logic [3:0] hit_slot;
        logic [2:0] zone;
        logic       focus_valid;
        logic [3:0] focus_slot;
    } t_outcome;

    // window table shadow
    logic        w_present [MAX_SLOTS];
    logic        w_visible [MAX_SLOTS];
    logic        w_minim [MAX_SLOTS];
    int          w_left [MAX_SLOTS];
    int          w_top [MAX_SLOTS];
    int          w_wid [MAX_SLOTS];
    int          w_hgt [MAX_SLOTS];
    logic [7:0]  w_depth [MAX_SLOTS];
    logic        has_focus;
    int          focus_owner;
    logic [7:0]  depth_ctr;
    int          cfg_border, cfg_button, cfg_title, cfg_grab;

    t_outcome    expected_q [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          quiet = 0;
    bit          out_noidle = 0;
    localparam int WATCHDOG = 2000;

    function automatic void raise_focus(int s);
        w_depth[s] = depth_ctr;
        depth_ctr++;
        has_focus = 1'b1;
        focus_owner = s;
    endfunction

    function automatic void refocus_top(bit skip_min);
        int best;
        logic [7:0] bz;
        bit found;
        best = 0;
        bz = 0;
        found = 0;
        has_focus = 1'b0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (!w_present[i] || !w_visible[i] || (skip_min && w_minim[i])) continue;
            if (w_depth[i] >= bz) begin
                bz = w_depth[i];
                best = i;
                found = 1;
            end
        end
        if (found) raise_focus(best);
    endfunction

    function automatic logic [2:0] pointer_zone(int rx, int ry, int ww, int wh);
        int cx, mx, nx;
        cx = ww - cfg_border - cfg_button;
        mx = cx - cfg_button;
        nx = mx - cfg_button;
        if (ry < cfg_title) begin
            if (rx >= cx && rx < cx + cfg_button) return ZONE_CLOSE;
            if (rx >= mx && rx < mx + cfg_button) return ZONE_MAX;
            if (rx >= nx && rx < nx + cfg_button) return ZONE_MIN;
            return ZONE_TITLE;
        end
        if (rx >= ww - cfg_grab && ry >= wh - cfg_grab) return ZONE_RESIZE;
        if (rx < cfg_border || rx >= ww - cfg_border || ry >= wh - cfg_border)
            return ZONE_BORDER;
        return ZONE_CLIENT;
    endfunction

    function automatic t_outcome apply_op(logic [2:0] md, int s, int px, int py,
                                          int ow, int oh);
        t_outcome r;
        bit ok, found;
        int best;
        logic [7:0] bz;
        r = '0;
        r.status = ST_IGNORED;
        ok = w_present[s];
        found = 0;
        best = 0;
        bz = 0;
        case (md)
            MODE_CREATE: begin
                r.status = ST_NO_FREE;
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    if (!w_present[i]) begin
                        w_present[i] = 1; w_visible[i] = 1; w_minim[i] = 0;
                        w_left[i] = px; w_top[i] = py; w_wid[i] = ow; w_hgt[i] = oh;
                        depth_ctr++;
                        raise_focus(i);
                        r.status = ST_DONE; r.hit_valid = 1; r.hit_slot = 4'(i);
                        break;
                    end
                end
            end
            MODE_DESTROY: if (ok) begin
                w_present[s] = 0; w_visible[s] = 0;
                if (has_focus && focus_owner == s) refocus_top(0);
                r.status = ST_DONE;
            end
            MODE_GEOMETRY: if (ok) begin
                w_left[s] = px; w_top[s] = py; w_wid[s] = ow; w_hgt[s] = oh;
                r.status = ST_DONE;
            end
            MODE_FOCUS: if (ok) begin
                raise_focus(s);
                r.status = ST_DONE;
            end
            MODE_MINIMIZE: if (ok && !w_minim[s]) begin
                w_minim[s] = 1;
                if (has_focus && focus_owner == s) refocus_top(1);
                r.status = ST_DONE;
            end
            MODE_RESTORE: if (ok && w_minim[s]) begin
                w_minim[s] = 0;
                raise_focus(s);
                r.status = ST_DONE;
            end
            MODE_HIT: begin
                r.status = ST_DONE;
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    if (!w_present[i] || !w_visible[i] || w_minim[i]) continue;
                    if (px < w_left[i] || py < w_top[i] || px >= w_left[i] + w_wid[i]
                        || py >= w_top[i] + w_hgt[i]) continue;
                    if (!found || w_depth[i] >= bz) begin
                        bz = w_depth[i]; best = i; found = 1;
                    end
                end
                if (found) begin
                    r.hit_valid = 1;
                    r.hit_slot = 4'(best);
                    r.zone = pointer_zone(px - w_left[best], py - w_top[best],
                                          w_wid[best], w_hgt[best]);
                end
            end
            default: ;
        endcase
        r.focus_valid = has_focus;
        r.focus_slot = has_focus ? focus_owner[3:0] : 4'd0;
        return r;
    endfunction

    task automatic send_op(int md, int s, int px, int py, int ow, int oh);
        int gap;
        logic [2:0] m;
        logic [3:0] sl;
        logic [15:0] x, y, w, h;
        m = md[2:0];
        sl = s[3:0];
        x = px[15:0];
        y = py[15:0];
        w = ow[15:0];
        h = oh[15:0];
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
        end
        i_mode <= m; i_slot <= sl; i_pos_x <= x; i_pos_y <= y;
        i_outer_w <= w; i_outer_h <= h;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_q.push_back(apply_op(m, int'(sl), int'($signed(x)), int'($signed(y)),
                                      int'(w), int'(h)));
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BORDER: cfg_border = val[5:0];
            CFG_BUTTON: cfg_button = val;
            CFG_TITLE:  cfg_title = val;
            default:    cfg_grab = val;
        endcase
    endtask

    task automatic set_chrome(int bw, int bt, int th, int rg);
        wait_drained();
        write_reg(CFG_BORDER, 8'(bw));
        write_reg(CFG_BUTTON, 8'(bt));
        write_reg(CFG_TITLE, 8'(th));
        write_reg(CFG_GRAB, 8'(rg));
    endtask

    // picks a slot, mostly a live one
    function automatic logic [3:0] pick_slot();
        for (int k = 0; k < 4; k++) begin
            int s;
            s = $urandom_range(0, MAX_SLOTS - 1);
            if (w_present[s]) return s[3:0];
        end
        return 4'($urandom_range(0, MAX_SLOTS - 1));
    endfunction

    // pointer near a live window so hits land on chrome regions
    task automatic send_hit_near();
        int s, dx, dy;
        s = pick_slot();
        if (w_present[s]) begin
            dx = $urandom_range(0, 1) ? $urandom_range(0, 80)
                                      : w_wid[s] - $urandom_range(0, 80);
            dy = $urandom_range(0, 1) ? $urandom_range(0, 60)
                                      : w_hgt[s] - $urandom_range(0, 40);
            send_op(MODE_HIT, 0, w_left[s] + dx - 2, w_top[s] + dy - 2, 0, 0);
        end else begin
            send_op(MODE_HIT, 0, $urandom, $urandom, 0, 0);
        end
    endtask

    task automatic test_directed;
        send_op(MODE_HIT, 0, 0, 0, 0, 0);
        send_op(MODE_DESTROY, 3, 0, 0, 0, 0);
        send_op(MODE_CREATE, 0, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_op(MODE_CREATE, 0, 100, 100, 300, 200);
        send_op(MODE_CREATE, 0, 7, 7, 0, 50);
        send_op(MODE_HIT, 0, 16'h7FFF, 16'h7FFF, 0, 0);
        send_op(MODE_HIT, 0, 380, 105, 0, 0);
        send_op(MODE_HIT, 0, 350, 105, 0, 0);
        send_op(MODE_HIT, 0, 330, 105, 0, 0);
        send_op(MODE_HIT, 0, 200, 105, 0, 0);
        send_op(MODE_HIT, 0, 397, 297, 0, 0);
        send_op(MODE_HIT, 0, 101, 200, 0, 0);
        send_op(MODE_HIT, 0, 200, 200, 0, 0);
        send_op(MODE_HIT, 0, 7, 7, 0, 0);
        send_op(MODE_FOCUS, 0, 0, 0, 0, 0);
        send_op(MODE_MINIMIZE, 0, 0, 0, 0, 0);
        send_op(MODE_MINIMIZE, 0, 0, 0, 0, 0);
        send_op(MODE_RESTORE, 1, 0, 0, 0, 0);
        send_op(MODE_RESTORE, 0, 0, 0, 0, 0);
        send_op(MODE_GEOMETRY, 2, 16'hFFFF, 16'h0001, 16'h8000, 16'h0100);
        send_op(MODE_DESTROY, 0, 0, 0, 0, 0);
        send_op(MODE_NONE, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 15; i++) send_op(MODE_CREATE, 0, i * 10, i * 10, 50, 50);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 12)
                send_op(MODE_CREATE, $urandom, $urandom_range(0, 400),
                        $urandom_range(0, 300), $urandom_range(0, 400),
                        $urandom_range(0, 300));
            else if (r < 14)
                send_op(MODE_CREATE, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 24) send_op(MODE_DESTROY, pick_slot(), $urandom, 0, 0, 0);
            else if (r < 32)
                send_op(MODE_GEOMETRY, pick_slot(), $urandom_range(0, 400),
                        $urandom_range(0, 300), $urandom_range(0, 400),
                        $urandom_range(0, 300));
            else if (r < 34)
                send_op(MODE_GEOMETRY, pick_slot(), $urandom, $urandom, $urandom,
                        $urandom);
            else if (r < 42) send_op(MODE_FOCUS, pick_slot(), 0, 0, 0, 0);
            else if (r < 50) send_op(MODE_MINIMIZE, pick_slot(), 0, 0, 0, 0);
            else if (r < 58) send_op(MODE_RESTORE, pick_slot(), 0, 0, 0, 0);
            else if (r < 60) send_op(MODE_NONE, $urandom, $urandom, $urandom, 0, 0);
            else if (r < 90) send_hit_near();
            else send_op(MODE_HIT, $urandom, $urandom_range(0, 700),
                         $urandom_range(0, 600), $urandom, $urandom);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_outcome got, want;
            got = {o_status, o_hit_valid, o_hit_slot, o_zone, o_focus_valid, o_focus_slot};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // result stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) i_stall <= 1'b0;
        end else if (!out_noidle && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(1, 10);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            w_present[i] = 0; w_visible[i] = 0; w_minim[i] = 0;
            w_left[i] = 0; w_top[i] = 0; w_wid[i] = 0; w_hgt[i] = 0; w_depth[i] = 0;
        end
        has_focus = 0; focus_owner = 0; depth_ctr = 1;
        cfg_border = 2; cfg_button = 24; cfg_title = 24; cfg_grab = 8;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        set_chrome(63, 255, 255, 255);
        test_random(300);
        set_chrome(0, 1, 1, 0);
        test_random(300);
        set_chrome(5, 10, 20, 30);
        test_random(300);
        set_chrome(2, 24, 24, 8);
        quiet = 1;
        out_noidle = 1;
        test_random(300);
        wait_drained();
        if (mismatches == 0 && expected_q.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire
